### design/dks_pkg.sv
`timescale 1ns / 1ps
// DES key schedule package: word types, permutation tables and helper functions.
package dks_pkg;

  localparam int unsigned HalfLen   = 28;
  localparam int unsigned NumRounds = 16;
  localparam int unsigned Pc2Len    = 24;
  localparam int unsigned GroupLen  = 6;

  localparam logic [3:0] LastSlot = 4'd15;

  typedef struct packed {
    logic [31:0] key_low_word;
    logic [31:0] key_high_word;
    logic        decrypt;
  } key_word_t;

  typedef struct packed {
    logic [3:0] slot;
    logic [5:0] c_group0;
    logic [5:0] c_group1;
    logic [5:0] c_group2;
    logic [5:0] c_group3;
    logic [5:0] d_group0;
    logic [5:0] d_group1;
    logic [5:0] d_group2;
    logic [5:0] d_group3;
    logic       last_subkey;
  } subkey_word_t;

  // PC-1, 1-based key positions
  localparam logic [5:0] PC1_C [0:27] = '{
    6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,
    6'd1,  6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18,
    6'd10, 6'd2,  6'd59, 6'd51, 6'd43, 6'd35, 6'd27,
    6'd19, 6'd11, 6'd3,  6'd60, 6'd52, 6'd44, 6'd36
  };

  localparam logic [5:0] PC1_D [0:27] = '{
    6'd63, 6'd55, 6'd47, 6'd39, 6'd31, 6'd23, 6'd15,
    6'd7,  6'd62, 6'd54, 6'd46, 6'd38, 6'd30, 6'd22,
    6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37, 6'd29,
    6'd21, 6'd13, 6'd5,  6'd28, 6'd20, 6'd12, 6'd4
  };

  // PC-2, 1-based positions in C (1..28) and D (29..56)
  localparam logic [5:0] PC2_C [0:23] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
    6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
    6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
    6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2
  };

  localparam logic [5:0] PC2_D [0:23] = '{
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
    6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
    6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
    6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Total left rotation of C and D after each round, modulo 28
  localparam logic [4:0] ROT_TOTAL [0:15] = '{
    5'd1,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14,
    5'd15, 5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd0
  };

  function automatic logic [27:0] pc1_c(input logic [63:0] key);
    logic [5:0] idx;
    pc1_c = '0;
    for (int j = 0; j < HalfLen; j++) begin
      idx = PC1_C[j] - 6'd1;
      pc1_c[j] = key[idx];
    end
  endfunction

  function automatic logic [27:0] pc1_d(input logic [63:0] key);
    logic [5:0] idx;
    pc1_d = '0;
    for (int j = 0; j < HalfLen; j++) begin
      idx = PC1_D[j] - 6'd1;
      pc1_d[j] = key[idx];
    end
  endfunction

  // Element j takes element j+n
  function automatic logic [27:0] rot_half(input logic [27:0] h, input logic [4:0] n);
    logic [55:0] dbl;
    dbl = {h, h} >> n;
    rot_half = dbl[27:0];
  endfunction

  function automatic logic [23:0] pc2_c(input logic [27:0] h);
    logic [5:0] idx;
    pc2_c = '0;
    for (int k = 0; k < Pc2Len; k++) begin
      idx = PC2_C[k] - 6'd1;
      pc2_c[k] = h[idx[4:0]];
    end
  endfunction

  function automatic logic [23:0] pc2_d(input logic [27:0] h);
    logic [5:0] idx;
    pc2_d = '0;
    for (int k = 0; k < Pc2Len; k++) begin
      idx = PC2_D[k] - 6'd29;
      pc2_d[k] = h[idx[4:0]];
    end
  endfunction

endpackage

### design/dks_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for key words and subkey words.
interface dks_key_if;
  import dks_pkg::*;

  logic      valid;
  logic      ready;
  key_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dks_subkey_if;
  import dks_pkg::*;

  logic         valid;
  logic         ready;
  subkey_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/des_key_schedule_top.sv
`timescale 1ns / 1ps
// DES key schedule top level: key word in, sixteen subkey words out.
//
//   channel    dir  interface      word
//   key_i      in   dks_key_if     key_low_word, key_high_word, decrypt
//   subkey_o   out  dks_subkey_if  slot, c/d groups 0..3, last_subkey
//
// A key word yields sixteen subkey words, one per cycle while the output is not
// stalled, counted off by the slot counter over the registered C/D halves.
// The next key is taken in the cycle the slot-15 word enters the output
// register, so keys stream back to back with no gap.
// Output stalls hold the slot counter; reset (rst_ni low) empties both stages.
module des_key_schedule_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  dks_key_if.sink             key_i,
  dks_subkey_if.source        subkey_o
);
  import dks_pkg::*;

  logic         work_valid_q, work_valid_d;
  logic [3:0]   slot_q, slot_d;
  logic [27:0]  c_q, c_d;
  logic [27:0]  d_q, d_d;
  logic         dec_q, dec_d;
  logic         out_valid_q, out_valid_d;
  subkey_word_t out_q, out_d;

  logic         advance;
  logic         key_acc;
  logic [3:0]   rnd;
  logic [27:0]  c_rot, d_rot;
  logic [23:0]  c_sel, d_sel;
  logic [63:0]  key;

  assign advance = work_valid_q && (!out_valid_q || subkey_o.ready);
  assign key_i.ready = !work_valid_q || (advance && slot_q == LastSlot);
  assign key_acc = key_i.valid && key_i.ready;

  assign key = {key_i.data.key_high_word, key_i.data.key_low_word};

  // decrypt walks rounds 15..0
  assign rnd   = dec_q ? ~slot_q : slot_q;
  assign c_rot = rot_half(c_q, ROT_TOTAL[rnd]);
  assign d_rot = rot_half(d_q, ROT_TOTAL[rnd]);
  assign c_sel = pc2_c(c_rot);
  assign d_sel = pc2_d(d_rot);

  always_comb begin
    work_valid_d = work_valid_q;
    slot_d       = slot_q;
    c_d          = c_q;
    d_d          = d_q;
    dec_d        = dec_q;
    if (key_acc) begin
      work_valid_d = 1'b1;
      slot_d       = '0;
      c_d          = pc1_c(key);
      d_d          = pc1_d(key);
      dec_d        = key_i.data.decrypt;
    end else if (advance) begin
      slot_d = slot_q + 4'd1;
      if (slot_q == LastSlot) begin
        work_valid_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d       = 1'b1;
      out_d.slot        = slot_q;
      out_d.c_group0    = c_sel[5:0];
      out_d.c_group1    = c_sel[11:6];
      out_d.c_group2    = c_sel[17:12];
      out_d.c_group3    = c_sel[23:18];
      out_d.d_group0    = d_sel[5:0];
      out_d.d_group1    = d_sel[11:6];
      out_d.d_group2    = d_sel[17:12];
      out_d.d_group3    = d_sel[23:18];
      out_d.last_subkey = (slot_q == LastSlot);
    end else if (subkey_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_valid_q <= 1'b0;
      slot_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      work_valid_q <= work_valid_d;
      slot_q       <= slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c_q   <= c_d;
    d_q   <= d_d;
    dec_q <= dec_d;
    out_q <= out_d;
  end

  assign subkey_o.valid = out_valid_q;
  assign subkey_o.data  = out_q;

`ifndef SYNTHESIS
  a_key_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_acc |=> work_valid_q && slot_q == '0)
    else $error("accepted key did not start at slot 0");

  a_slot_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && slot_q != LastSlot |=> work_valid_q && slot_q == $past(slot_q) + 4'd1)
    else $error("slot counter skipped or lost the run");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    work_valid_q && !advance |=> work_valid_q && $stable(slot_q))
    else $error("slot counter moved during output stall");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.last_subkey == (out_q.slot == LastSlot))
    else $error("last_subkey disagrees with slot");
`endif

endmodule
